// ----- src/pcomf_pkg.sv -----
// Package for the peer clock-offset min filter.
// Types, status codes and request codes shared by the core and its testbench.
// Depends on nothing.
package pcomf_pkg;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	localparam logic [2:0] ST_STORED    = 3'd0;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_QUERY_OK  = 3'd3;
	localparam logic [2:0] ST_NO_PEERS  = 3'd4;

	localparam logic [63:0] POS_MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic        req_type;
		logic [31:0] peer_ip;
		logic [31:0] magic;
		logic [63:0] remote_time;
		logic [63:0] local_time;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] peer_offset;
		logic [63:0] synced_time;
		logic [5:0]  peer_count;
	} out_item_t;

endpackage

// ----- src/pcomf_min_unit.sv -----
// Shared signed-minimum unit for the peer clock-offset min filter.
// One 64-bit compare per cycle; the sequencer in the core feeds it samples.
// Depends on pcomf_pkg.
module pcomf_min_unit (
	input  logic        clk,
	input  logic        start,
	input  logic        take,
	input  logic [63:0] sample,
	output logic [63:0] min_val
);

	logic [63:0] min_q;

	// restart at the largest positive value, fold one sample per take
	always_ff @(posedge clk) begin
		if (start) begin
			min_q <= pcomf_pkg::POS_MAX64;
		end else if (take && ($signed(sample) < $signed(min_q))) begin
			min_q <= sample;
		end
	end

	assign min_val = min_q;

endmodule

// ----- src/peer_clock_offset_min_filter_core.sv -----
// Peer clock-offset min filter, top level.
// Holds the peer table, sample memory and sequencer; uses pcomf_min_unit and pcomf_pkg.
//
// Usage:
//   in_valid/in_stall carry one request item (sample or query); out_valid/out_stall
//   carry one result item per request. expected_magic is written with cfg_we/cfg_wdata
//   while the block is idle.
//   A request is taken only when the block is idle and the output register is empty
//   or being drained. A sample walks the peer table, writes the sample, walks the
//   peer window in memory over its filled slots, then forms the result (S_DRAIN)
//   and registers it (S_OUT), where it waits while a held result is still stalled.
//   A query skips the write. No new request is taken until the result is
//   registered; the single memory read port and the one-compare-per-cycle minimum
//   unit make the window walk sequential. A bad magic sample skips both walks and
//   goes from S_SCAN straight to S_OUT.
//   Reset empties the peer table and clears expected_magic; memory contents need no
//   clearing since only filled slots are read. While out_stall is high a pending
//   result holds and no new item is taken.
module peer_clock_offset_min_filter_core #(
	parameter int MAX_PEERS    = 32,
	parameter int WINDOW_DEPTH = 120
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  pcomf_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output pcomf_pkg::out_item_t out_item,
	input  logic                 cfg_we,
	input  logic [31:0]          cfg_wdata
);

	localparam int PW   = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
	localparam int CW   = $clog2(MAX_PEERS + 1);
	localparam int WW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int FW   = $clog2(WINDOW_DEPTH + 1);
	localparam int DEPTH = MAX_PEERS * WINDOW_DEPTH;
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_WRITE, S_MIN, S_DRAIN, S_OUT
	} state_t;

	state_t state_q;
	pcomf_pkg::in_item_t req_q;
	logic [31:0]   magic_q;
	logic [31:0]   addr_q   [MAX_PEERS];
	logic [MAX_PEERS-1:0] valid_q;
	logic [WW-1:0] wslot_q  [MAX_PEERS];
	logic [FW-1:0] fill_q   [MAX_PEERS];
	logic [CW-1:0] total_q;
	logic [PW-1:0] ref_q;
	logic [CW-1:0] pidx_q;
	logic          found_q, free_ok_q, any_q;
	logic [PW-1:0] found_idx_q, free_idx_q, best_q;
	logic [FW-1:0] ridx_q;
	logic          rd_vld_q;
	logic [63:0]   mem [DEPTH];
	logic [63:0]   rdata_q;
	logic [AW-1:0] base_q;
	logic          out_valid_q;
	pcomf_pkg::out_item_t out_q;
	logic          min_start, min_take;
	logic [63:0]   min_val;
	logic [PW-1:0] p;
	logic [PW-1:0] tgt;

	pcomf_min_unit u_min (
		.clk(clk), .start(min_start), .take(min_take),
		.sample(rdata_q), .min_val(min_val)
	);

	assign p    = pidx_q[PW-1:0];
	assign tgt  = (req_q.req_type == pcomf_pkg::REQ_QUERY) ? best_q : found_idx_q;
	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign min_start = (state_q == S_WRITE) || (state_q == S_SCAN && pidx_q == CW'(MAX_PEERS));
	assign min_take  = rd_vld_q && (state_q == S_MIN || state_q == S_DRAIN);

	// sample memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (state_q == S_WRITE) begin
			mem[AW'(32'(found_idx_q) * WINDOW_DEPTH + 32'(wslot_q[found_idx_q]))] <=
				req_q.local_time - req_q.remote_time;
		end
		rdata_q <= mem[AW'(32'(base_q) + 32'(ridx_q))];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			magic_q     <= '0;
			valid_q     <= '0;
			total_q     <= '0;
			ref_q       <= '0;
			out_valid_q <= 1'b0;
			pidx_q      <= '0;
			ridx_q      <= '0;
			rd_vld_q    <= 1'b0;
			for (int i = 0; i < MAX_PEERS; i++) begin
				wslot_q[i] <= '0;
				fill_q[i]  <= '0;
			end
		end else begin
			if (cfg_we) magic_q <= cfg_wdata;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && !(out_valid_q && out_stall)) begin
						req_q     <= in_item;
						pidx_q    <= '0;
						found_q   <= 1'b0;
						free_ok_q <= 1'b0;
						any_q     <= 1'b0;
						best_q    <= '0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (req_q.req_type == pcomf_pkg::REQ_SAMPLE &&
					    req_q.magic != magic_q) begin
						out_q.status      <= pcomf_pkg::ST_BAD_MAGIC;
						out_q.peer_offset <= '0;
						out_q.synced_time <= '0;
						out_q.peer_count  <= 6'(total_q);
						state_q <= S_OUT;
					end else if (pidx_q != CW'(MAX_PEERS)) begin
						if (valid_q[p]) begin
							if (addr_q[p] == req_q.peer_ip && !found_q) begin
								found_q <= 1'b1;
								found_idx_q <= p;
							end
							if (!any_q || addr_q[p] < addr_q[best_q]) begin
								best_q <= p;
								any_q  <= 1'b1;
							end
						end else if (!free_ok_q) begin
							free_ok_q  <= 1'b1;
							free_idx_q <= p;
						end
						pidx_q <= pidx_q + 1'b1;
					end else if (req_q.req_type == pcomf_pkg::REQ_QUERY) begin
						if (any_q) begin
							ref_q   <= best_q;
							base_q  <= AW'(32'(best_q) * WINDOW_DEPTH);
							ridx_q  <= '0;
							rd_vld_q <= 1'b0;
							state_q <= S_MIN;
						end else begin
							out_q.status      <= pcomf_pkg::ST_NO_PEERS;
							out_q.peer_offset <= '0;
							out_q.synced_time <= req_q.local_time;
							out_q.peer_count  <= 6'(total_q);
							state_q <= S_OUT;
						end
					end else if (!found_q && !free_ok_q) begin
						out_q.status      <= pcomf_pkg::ST_FULL;
						out_q.peer_offset <= '0;
						out_q.synced_time <= '0;
						out_q.peer_count  <= 6'(total_q);
						state_q <= S_OUT;
					end else begin
						if (!found_q) begin
							found_idx_q        <= free_idx_q;
							valid_q[free_idx_q] <= 1'b1;
							addr_q[free_idx_q]  <= req_q.peer_ip;
							wslot_q[free_idx_q] <= '0;
							fill_q[free_idx_q]  <= '0;
							total_q <= total_q + 1'b1;
						end
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (32'(wslot_q[found_idx_q]) >= WINDOW_DEPTH - 1) begin
						wslot_q[found_idx_q] <= '0;
					end else begin
						wslot_q[found_idx_q] <= wslot_q[found_idx_q] + 1'b1;
					end
					if (32'(fill_q[found_idx_q]) < WINDOW_DEPTH)
						fill_q[found_idx_q] <= fill_q[found_idx_q] + 1'b1;
					base_q   <= AW'(32'(found_idx_q) * WINDOW_DEPTH);
					ridx_q   <= '0;
					rd_vld_q <= 1'b0;
					state_q  <= S_MIN;
				end
				S_MIN: begin
					// issue one read per cycle over the filled slots
					if (ridx_q != fill_q[tgt]) begin
						ridx_q   <= ridx_q + 1'b1;
						rd_vld_q <= 1'b1;
					end else begin
						rd_vld_q <= 1'b0;
						state_q  <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					out_q.peer_count <= 6'(total_q);
					if (req_q.req_type == pcomf_pkg::REQ_QUERY) begin
						out_q.status      <= pcomf_pkg::ST_QUERY_OK;
						out_q.peer_offset <= min_val;
						out_q.synced_time <= req_q.local_time - min_val;
					end else begin
						out_q.status      <= pcomf_pkg::ST_STORED;
						out_q.peer_offset <= min_val;
						out_q.synced_time <= '0;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!(out_valid_q && out_stall)) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// no new item while busy
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("item taken while busy");
	// count never above table size
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(total_q) <= MAX_PEERS))
		else $error("peer count overflow");
	// count matches valid bits
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(total_q) == $countones(valid_q)))
		else $error("peer count mismatch");
	// held result does not change under stall
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> $stable(out_q))
		else $error("result changed under stall");

endmodule

// ----- tb/peer_clock_offset_min_filter_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for peer_clock_offset_min_filter_core.
// It predicts each result item from its own peer table model and checks it field by field.
// Depends on pcomf_pkg and the core RTL.
module peer_clock_offset_min_filter_core_tb;

	localparam int NPEER = 32;
	localparam int WDEPTH = 120;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	pcomf_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	pcomf_pkg::out_item_t out_item;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	peer_clock_offset_min_filter_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// predictor state
	logic [31:0] magic_word;
	logic [31:0] addr_tab [NPEER];
	logic peer_used [NPEER];
	logic [63:0] offsets [NPEER][WDEPTH];
	int wr_pos [NPEER];
	int fill [NPEER];
	int npeers;

	pcomf_pkg::in_item_t pending_items[$];
	pcomf_pkg::out_item_t expected_results[$];
	int send_idle_pct, recv_idle_pct;
	int errors, items_sent, results_seen, stored_cnt, full_cnt, bad_cnt, query_cnt;
	int quiet_cycles;

	function automatic logic [63:0] window_minimum(int p);
		logic [63:0] m;
		m = pcomf_pkg::POS_MAX64;
		for (int i = 0; i < fill[p]; i++)
			if ($signed(offsets[p][i]) < $signed(m))
				m = offsets[p][i];
		return m;
	endfunction

	function automatic pcomf_pkg::out_item_t predict_result(pcomf_pkg::in_item_t it);
		pcomf_pkg::out_item_t r;
		int found, freep, best;
		r = '0;
		if (it.req_type == pcomf_pkg::REQ_SAMPLE) begin
			if (it.magic != magic_word) begin
				r.status = pcomf_pkg::ST_BAD_MAGIC;
			end else begin
				found = NPEER;
				freep = NPEER;
				for (int p = 0; p < NPEER; p++) begin
					if (peer_used[p]) begin
						if (addr_tab[p] == it.peer_ip && found == NPEER)
							found = p;
					end else if (freep == NPEER) begin
						freep = p;
					end
				end
				if (found == NPEER && freep < NPEER) begin
					found = freep;
					peer_used[found] = 1'b1;
					addr_tab[found] = it.peer_ip;
					wr_pos[found] = 0;
					fill[found] = 0;
					npeers++;
				end
				if (found == NPEER) begin
					r.status = pcomf_pkg::ST_FULL;
				end else begin
					offsets[found][wr_pos[found]] = it.local_time - it.remote_time;
					wr_pos[found] = (wr_pos[found] + 1) % WDEPTH;
					if (fill[found] < WDEPTH)
						fill[found]++;
					r.peer_offset = window_minimum(found);
					r.status = pcomf_pkg::ST_STORED;
				end
			end
		end else begin
			best = -1;
			for (int p = 0; p < NPEER; p++)
				if (peer_used[p] && (best < 0 || addr_tab[p] < addr_tab[best]))
					best = p;
			if (best >= 0) begin
				r.peer_offset = window_minimum(best);
				r.synced_time = it.local_time - r.peer_offset;
				r.status = pcomf_pkg::ST_QUERY_OK;
			end else begin
				r.synced_time = it.local_time;
				r.status = pcomf_pkg::ST_NO_PEERS;
			end
		end
		r.peer_count = 6'(npeers);
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_item <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// predict on acceptance, check results
	always @(posedge clk) begin
		int n_err;
		pcomf_pkg::out_item_t e;
		n_err = 0;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (in_valid && !in_stall) begin
				expected_results.push_back(predict_result(in_item));
				items_sent <= items_sent + 1;
			end
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result item %p", $time, out_item);
					n_err = n_err + 1;
				end else begin
					e = expected_results.pop_front();
					case (out_item.status)
						pcomf_pkg::ST_STORED: stored_cnt <= stored_cnt + 1;
						pcomf_pkg::ST_FULL: full_cnt <= full_cnt + 1;
						pcomf_pkg::ST_BAD_MAGIC: bad_cnt <= bad_cnt + 1;
						default: query_cnt <= query_cnt + 1;
					endcase
					if (out_item.status !== e.status) begin
						$display("%0t: status expected %0d actual %0d", $time, e.status,
							out_item.status);
						n_err = n_err + 1;
					end
					if (out_item.peer_offset !== e.peer_offset) begin
						$display("%0t: peer_offset expected %h actual %h", $time,
							e.peer_offset, out_item.peer_offset);
						n_err = n_err + 1;
					end
					if (out_item.synced_time !== e.synced_time) begin
						$display("%0t: synced_time expected %h actual %h", $time,
							e.synced_time, out_item.synced_time);
						n_err = n_err + 1;
					end
					if (out_item.peer_count !== e.peer_count) begin
						$display("%0t: peer_count expected %0d actual %0d", $time,
							e.peer_count, out_item.peer_count);
						n_err = n_err + 1;
					end
				end
			end
			errors <= errors + n_err;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired", $time);
				$display("status: fail");
				$finish;
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic pcomf_pkg::in_item_t make_sample(logic [31:0] ip, logic [31:0] mg,
		logic [63:0] rt, logic [63:0] lt);
		pcomf_pkg::in_item_t it;
		it.req_type = pcomf_pkg::REQ_SAMPLE;
		it.peer_ip = ip;
		it.magic = mg;
		it.remote_time = rt;
		it.local_time = lt;
		return it;
	endfunction

	function automatic pcomf_pkg::in_item_t make_query(logic [63:0] lt);
		pcomf_pkg::in_item_t it;
		it.req_type = pcomf_pkg::REQ_QUERY;
		it.peer_ip = $urandom();
		it.magic = $urandom();
		it.remote_time = rand64();
		it.local_time = lt;
		return it;
	endfunction

	// drain all results, then let the block settle
	task automatic wait_idle();
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (NPEER + WDEPTH + 8) @(posedge clk);
	endtask

	task automatic write_magic(logic [31:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		magic_word = v;
	endtask

	// random phase: a working set of peers, mostly good samples
	task automatic random_phase(int n, logic [31:0] mg, int pool);
		logic [31:0] ips [8];
		logic [63:0] base;
		int k;
		for (int i = 0; i < 8; i++)
			ips[i] = (i == 0) ? 32'hFFFF_FFFF : $urandom();
		base = rand64();
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			base = base + $urandom_range(2000000);
			if (k < 12)
				pending_items.push_back(make_query(($urandom_range(9) == 0) ? rand64() : base));
			else if (k < 18)
				pending_items.push_back(make_sample(ips[$urandom_range(pool - 1)],
					mg ^ (32'h1 << $urandom_range(31)), rand64(), rand64()));
			else if (k < 22)
				pending_items.push_back(make_sample($urandom(), mg, rand64(), rand64()))
					;
			else
				pending_items.push_back(make_sample(ips[$urandom_range(pool - 1)], mg,
					base - 64'($urandom_range(500000)) + rand64() * ($urandom_range(19) == 0),
					base));
		end
	endtask

	initial begin
		magic_word = '0;
		npeers = 0;
		for (int p = 0; p < NPEER; p++) begin
			peer_used[p] = 1'b0;
			wr_pos[p] = 0;
			fill[p] = 0;
			addr_tab[p] = '0;
		end
		errors = 0; items_sent = 0; results_seen = 0; quiet_cycles = 0;
		stored_cnt = 0; full_cnt = 0; bad_cnt = 0; query_cnt = 0;
		send_idle_pct = 19;
		recv_idle_pct = 49;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty query, reset magic, extremes, bad magic, full table
		pending_items.push_back(make_query(64'h8000_0000_0000_0000));
		pending_items.push_back(make_sample(32'h0, 32'h0, 64'h8000_0000_0000_0000,
			64'h7FFF_FFFF_FFFF_FFFF));
		pending_items.push_back(make_sample(32'h1, 32'h1, 64'h0, 64'h0));
		wait_idle();
		write_magic(32'hFFFF_FFFF);
		pending_items.push_back(make_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF,
			64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000));
		pending_items.push_back(make_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h1, 64'h0));
		pending_items.push_back(make_query(64'h7FFF_FFFF_FFFF_FFFF));
		pending_items.push_back(make_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 64'h0, 64'h0));
		// fill the table, then one more unknown peer
		for (int i = 2; i < NPEER + 1; i++)
			pending_items.push_back(make_sample(32'h1000 + i, 32'hFFFF_FFFF, 64'h5, 64'h9));
		pending_items.push_back(make_query(64'h0));
		// hold the sender until every result is back
		wait_idle();

		write_magic($urandom());
		random_phase(380, magic_word, 8);
		send_idle_pct = 49;
		recv_idle_pct = 19;
		write_magic($urandom());
		random_phase(380, magic_word, 3);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_magic(32'h0000_0000);
		random_phase(360, magic_word, 8);
		wait_idle();

		$display("covered %0d items, %0d results: %0d stored, %0d bad magic, %0d table full",
			items_sent, results_seen, stored_cnt, bad_cnt, full_cnt);
		$display("and %0d queries, under both stall mixes and at full rate", query_cnt);
		if (errors == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
